[hw/rtl/psq_pkg.sv]
// Package for the PSK squelch and signal quality estimator.
// Holds widths, fixed-point constants, codes and the sequencer state type.
// No dependencies; the RTL files use it by scoped names and the test files import it.
package psq_pkg;

  // Fixed point and field widths
  localparam int FRAC_BITS  = 16;
  localparam int PHASE_W    = 16;
  localparam int AGC_W      = 24;
  localparam int LEVEL_W    = 9;
  localparam int THRESH_W   = 7;
  localparam int SPEED_W    = 10;
  localparam int MODE_W     = 2;
  localparam int FAST_W     = 1;
  localparam int PEA_W      = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  // Angle-to-radian conversion: 2*pi scaled by 2^32, result taken above bit RAD_SHIFT.
  localparam int          TWOPI_W   = 35;
  localparam logic [34:0] TWOPI_Q32 = 35'd26986075409;
  localparam int          RAD_SHIFT = 48 - FRAC_BITS;
  localparam int          MAG_W     = PHASE_W - 1;          // window offset magnitude
  localparam int          ALU_W     = MAG_W + TWOPI_W;      // shared adder width

  localparam int ERR_W   = FRAC_BITS + 2;   // |phase error|, below pi
  localparam int HELD_W  = ERR_W + 1;       // signed phase error
  localparam int AVG_W   = FRAC_BITS + 8;   // deviation average
  localparam int DEV_W   = ERR_W + 9;       // error times the deviation gain
  localparam int EAVG_W  = PEA_W;           // phase error average
  localparam int DIV_W   = AVG_W + 1;       // dividend and quotient
  localparam int DEN_W   = SPEED_W + 1;     // divisor, up to twice the speed
  localparam int CNT_W   = $clog2(DIV_W + 1);
  localparam int RUN_W   = 8;
  localparam int SEQ_W   = 5;               // on and off run counters

  // Window edges and centers, in fractions of a turn
  localparam logic [PHASE_W:0] HALF_TURN   = 17'd32768;
  localparam logic [PHASE_W:0] CENTER_180  = 17'd16384;
  localparam logic [PHASE_W:0] CENTER_0    = 17'd49152;
  localparam logic [PHASE_W:0] Q180_LO     = 17'd8192;
  localparam logic [PHASE_W:0] Q180_HI     = 17'd24576;
  localparam logic [PHASE_W:0] Q0_LO       = 17'd40960;
  localparam logic [PHASE_W:0] Q0_HI       = 17'd57344;

  localparam logic [AVG_W-1:0]  AVG_RESET  = AVG_W'(((64'd2 << FRAC_BITS) + 64'd2) / 64'd5);
  localparam logic [AVG_W-1:0]  AVG_OPEN   = AVG_W'(64'd25 << FRAC_BITS);
  localparam logic [AVG_W-1:0]  AVG_CLOSE  = AVG_W'(64'd100 << FRAC_BITS);
  localparam logic [HELD_W-1:0] LIM_QPSK   = HELD_W'(((64'd3 << FRAC_BITS) + 64'd2) / 64'd5);
  localparam logic [HELD_W-1:0] LIM_BPSK   = HELD_W'(64'd1 << FRAC_BITS);
  localparam logic [AGC_W-1:0]  AGC_GATE   = 24'd2560;        // 10.0 in Q16.8

  localparam logic [8:0]        DEV_K_QPSK = 9'd280;
  localparam logic [8:0]        DEV_K_BPSK = 9'd150;
  localparam logic [DEN_W-1:0]  NK_FAST    = DEN_W'(30);
  localparam logic [DEN_W-1:0]  NK_SLOW    = DEN_W'(100);
  localparam logic [RUN_W-1:0]  ELIMIT     = RUN_W'(5);
  localparam logic [RUN_W-1:0]  RUN_MAX    = RUN_W'(255);
  localparam logic [SEQ_W-1:0]  SEQ_STOP   = SEQ_W'(20);
  localparam logic [SEQ_W-1:0]  IMD_MIN    = SEQ_W'(2);
  localparam logic [LEVEL_W-1:0] LEVEL_FULL = LEVEL_W'(100);

  typedef enum logic [MODE_W-1:0] {
    MODE_BPSK     = 2'd0,
    MODE_QPSK_USB = 2'd1,
    MODE_QPSK_LSB = 2'd2,
    MODE_SPARE    = 2'd3
  } rx_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RX_MODE   = 2'd0,
    CFG_SQL_SPEED = 2'd1,
    CFG_SQL_THR   = 2'd2,
    CFG_FAST_AFC  = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_DEV,
    ST_SUB,
    ST_ABS,
    ST_RND,
    ST_DIV,
    ST_UPD,
    ST_CLAMP,
    ST_DONE
  } psq_state_t;

endpackage

[hw/rtl/psq_in_if.sv]
// Input channel of the squelch estimator: one symbol angle and AGC level per transaction.
// Depends on psq_pkg for the field widths.
interface psq_in_if;
  logic                         valid;
  logic                         ready;
  logic [psq_pkg::PHASE_W-1:0]  phase_angle;
  logic [psq_pkg::AGC_W-1:0]    agc_level;

  modport source (output valid, output phase_angle, output agc_level, input ready);
  modport sink   (input valid, input phase_angle, input agc_level, output ready);
endinterface

[hw/rtl/psq_out_if.sv]
// Result channel of the squelch estimator: level, flags and phase error average.
// Depends on psq_pkg for the field widths.
interface psq_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [psq_pkg::LEVEL_W-1:0] squelch_level;
  logic                               squelch_open;
  logic                               imd_valid;
  logic signed [psq_pkg::PEA_W-1:0]   phase_error_avg;

  modport source (output valid, output squelch_level, output squelch_open,
                  output imd_valid, output phase_error_avg, input ready);
  modport sink   (input valid, input squelch_level, input squelch_open,
                  input imd_valid, input phase_error_avg, output ready);
endinterface

[hw/rtl/psq_cfg_if.sv]
// Configuration write channel of the squelch estimator: register index and data.
// Depends on psq_pkg for the field widths.
interface psq_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [psq_pkg::CFG_IDX_W-1:0]  index;
  logic [psq_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/psk_squelch_quality_estimator_top.sv]
// PSK phase-dispersion squelch and signal quality estimator, top level.
// Depends on psq_pkg and the interfaces psq_in_if, psq_out_if and psq_cfg_if.
//
// One transaction on the input channel carries the difference angle of one PSK symbol
// (plus pi, as a fraction of a turn) and the current AGC level; it produces exactly one
// result transaction with the squelch level, the open flag, the IMD-valid flag and the
// phase-derived frequency error average in Q.16. The bit-serial product, the averages
// and the division run through a single shared adder/subtractor under a small
// sequencer, so the block takes one symbol at a time and drops in_chan.ready while it
// works. A symbol in one of the windows goes through a bit-serial multiplication of
// its 15-bit window offset into radians and a sign-run step, then two passes (subtract,
// magnitude, rounding, 25 restoring-division steps, update) for the deviation average
// and the phase error average with a clamp step between them, and a final output step.
// A QPSK symbol outside both windows skips everything before the clamp step.
// The result sits in an output register, so the next symbol can be accepted while it
// waits to be taken; the block only stalls at its final step if the previous result is
// still unclaimed. Configuration writes are always accepted (cfg_chan.ready is tied
// high) and are meant to be issued only while the block is idle.
module psk_squelch_quality_estimator_top (
  input  logic      clk,
  input  logic      rst_n,
  psq_in_if.sink    in_chan,
  psq_out_if.source out_chan,
  psq_cfg_if.sink   cfg_chan
);

  // Configuration registers
  logic [psq_pkg::MODE_W-1:0]   rx_mode_r;
  logic [psq_pkg::SPEED_W-1:0]  sql_speed_r;
  logic [psq_pkg::THRESH_W-1:0] sql_thr_r;
  logic                         fast_afc_r;

  // Sequencer and persistent state
  psq_pkg::psq_state_t                state_r, state_nxt;
  logic                               phase_r, phase_nxt;     // 0: deviation pass, 1: error pass
  logic [psq_pkg::AVG_W-1:0]          avg_r, avg_nxt;
  logic signed [psq_pkg::EAVG_W-1:0]  eavg_r, eavg_nxt;
  logic signed [psq_pkg::HELD_W-1:0]  held_r, held_nxt;
  logic [psq_pkg::SEQ_W-1:0]          on_run_r, on_run_nxt;
  logic [psq_pkg::SEQ_W-1:0]          off_run_r, off_run_nxt;
  logic [psq_pkg::RUN_W-1:0]          pos_run_r, pos_run_nxt;
  logic [psq_pkg::RUN_W-1:0]          neg_run_r, neg_run_nxt;
  logic                               out_valid_r, out_valid_nxt;

  // Working registers of the shared unit
  logic [psq_pkg::ALU_W-1:0]    acc_r, acc_nxt;
  logic [psq_pkg::ALU_W-1:0]    mcand_r, mcand_nxt;
  logic [psq_pkg::MAG_W-1:0]    mplier_r, mplier_nxt;
  logic [psq_pkg::DIV_W-1:0]    div_r, div_nxt;
  logic [psq_pkg::DEN_W-1:0]    rem_r, rem_nxt;
  logic [psq_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                         num_neg_r, num_neg_nxt;
  logic                         diff_neg_r, diff_neg_nxt;
  logic                         in180_r, in180_nxt;
  logic [psq_pkg::AGC_W-1:0]    agc_r, agc_nxt;

  // Output registers
  logic signed [psq_pkg::LEVEL_W-1:0] level_r, level_nxt;
  logic                               open_r, open_nxt;
  logic                               imd_r, imd_nxt;
  logic signed [psq_pkg::PEA_W-1:0]   pea_r, pea_nxt;

  // Shared adder/subtractor
  logic [psq_pkg::ALU_W-1:0] alu_a, alu_b, alu_y;
  logic                      alu_sub;

  assign alu_y = alu_a + (alu_sub ? ~alu_b : alu_b) + psq_pkg::ALU_W'(alu_sub);

  // Mode decode; the spare mode code behaves as QPSK upper sideband.
  logic qpsk, lower;
  assign qpsk  = (rx_mode_r != psq_pkg::MODE_BPSK);
  assign lower = (rx_mode_r == psq_pkg::MODE_QPSK_LSB);

  // Window sorting of the incoming angle
  logic [psq_pkg::PHASE_W:0]   p_ext, centre;
  logic                        win180, win0;
  logic [psq_pkg::PHASE_W:0]   diff;
  logic [psq_pkg::PHASE_W:0]   diff_mag;

  always_comb begin
    p_ext = {1'b0, in_chan.phase_angle};
    if (qpsk) begin
      win180 = (p_ext >= psq_pkg::Q180_LO) && (p_ext <= psq_pkg::Q180_HI);
      win0   = (p_ext >= psq_pkg::Q0_LO) && (p_ext <= psq_pkg::Q0_HI);
    end else begin
      // Exactly one half turn counts as a 180-degree symbol.
      win180 = (p_ext <= psq_pkg::HALF_TURN);
      win0   = !win180;
    end
    centre   = win180 ? psq_pkg::CENTER_180 : psq_pkg::CENTER_0;
    diff     = lower ? (centre - p_ext) : (p_ext - centre);
    diff_mag = diff[psq_pkg::PHASE_W] ? (~diff + 1'b1) : diff;
  end

  // Divisor: the squelch speed (doubled when the deviation rises) or the AFC constant.
  logic [psq_pkg::DEN_W-1:0] speed_k, den;
  always_comb begin
    speed_k = (sql_speed_r == '0) ? psq_pkg::DEN_W'(1) : psq_pkg::DEN_W'(sql_speed_r);
    if (phase_r) begin
      den = fast_afc_r ? psq_pkg::NK_FAST : psq_pkg::NK_SLOW;
    end else begin
      den = num_neg_r ? speed_k : (speed_k << 1);
    end
  end

  // Phase error from the multiplier result, and the deviation it implies
  logic [psq_pkg::ERR_W-1:0]         err_mag;
  logic                              err_neg;
  logic signed [psq_pkg::HELD_W-1:0] err_s;
  logic [psq_pkg::DEV_W-1:0]         dev_full;

  assign err_mag  = acc_r[psq_pkg::RAD_SHIFT +: psq_pkg::ERR_W];
  assign err_neg  = diff_neg_r && (err_mag != '0);
  assign err_s    = err_neg ? -$signed({1'b0, err_mag}) : $signed({1'b0, err_mag});
  assign dev_full = psq_pkg::DEV_W'(err_mag)
                  * psq_pkg::DEV_W'(qpsk ? psq_pkg::DEV_K_QPSK : psq_pkg::DEV_K_BPSK);

  // Clamp of the held error to the mode's limit
  logic signed [psq_pkg::HELD_W-1:0] lim, held_c;
  always_comb begin
    lim = qpsk ? $signed(psq_pkg::LIM_QPSK) : $signed(psq_pkg::LIM_BPSK);
    if (held_r > lim) begin
      held_c = lim;
    end else if (held_r < -lim) begin
      held_c = -lim;
    end else begin
      held_c = held_r;
    end
  end

  // Squelch level from the final deviation average
  logic signed [psq_pkg::LEVEL_W-1:0] level_v;
  assign level_v = $signed(psq_pkg::LEVEL_FULL
                 - psq_pkg::LEVEL_W'(avg_r[psq_pkg::AVG_W-1:psq_pkg::FRAC_BITS]));

  logic in_fire;
  assign in_chan.ready  = (state_r == psq_pkg::ST_IDLE);
  assign in_fire        = in_chan.valid && in_chan.ready;
  assign cfg_chan.ready = 1'b1;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    avg_nxt       = avg_r;
    eavg_nxt      = eavg_r;
    held_nxt      = held_r;
    on_run_nxt    = on_run_r;
    off_run_nxt   = off_run_r;
    pos_run_nxt   = pos_run_r;
    neg_run_nxt   = neg_run_r;
    acc_nxt       = acc_r;
    mcand_nxt     = mcand_r;
    mplier_nxt    = mplier_r;
    div_nxt       = div_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    num_neg_nxt   = num_neg_r;
    diff_neg_nxt  = diff_neg_r;
    in180_nxt     = in180_r;
    agc_nxt       = agc_r;
    level_nxt     = level_r;
    open_nxt      = open_r;
    imd_nxt       = imd_r;
    pea_nxt       = pea_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    alu_a         = '0;
    alu_b         = '0;
    alu_sub       = 1'b0;

    unique case (state_r)
      psq_pkg::ST_IDLE: begin
        if (in_fire) begin
          agc_nxt      = in_chan.agc_level;
          in180_nxt    = win180;
          diff_neg_nxt = diff[psq_pkg::PHASE_W];
          if (win180 || win0) begin
            // Rounding constant preloaded so the product needs no final add.
            acc_nxt    = psq_pkg::ALU_W'(1) << (psq_pkg::RAD_SHIFT - 1);
            mcand_nxt  = psq_pkg::ALU_W'(psq_pkg::TWOPI_Q32);
            mplier_nxt = diff_mag[psq_pkg::MAG_W-1:0];
            cnt_nxt    = psq_pkg::CNT_W'(psq_pkg::MAG_W);
            phase_nxt  = 1'b0;
            state_nxt  = psq_pkg::ST_MUL;
          end else begin
            // Outside both windows only the error average moves.
            phase_nxt  = 1'b1;
            state_nxt  = psq_pkg::ST_CLAMP;
          end
        end
      end

      psq_pkg::ST_MUL: begin
        alu_a = acc_r;
        alu_b = mcand_r;
        if (mplier_r[0]) begin
          acc_nxt = alu_y;
        end
        mcand_nxt  = mcand_r << 1;
        mplier_nxt = mplier_r >> 1;
        cnt_nxt    = cnt_r - 1'b1;
        if (cnt_r == psq_pkg::CNT_W'(1)) begin
          state_nxt = psq_pkg::ST_DEV;
        end
      end

      psq_pkg::ST_DEV: begin
        // Sign runs gate the held error: it passes only after ELIMIT of one sign.
        if (!err_neg) begin
          pos_run_nxt = (pos_run_r < psq_pkg::RUN_MAX) ? pos_run_r + 1'b1 : pos_run_r;
          neg_run_nxt = '0;
        end else begin
          neg_run_nxt = (neg_run_r < psq_pkg::RUN_MAX) ? neg_run_r + 1'b1 : neg_run_r;
          pos_run_nxt = '0;
        end
        if ((pos_run_nxt < psq_pkg::ELIMIT) && (neg_run_nxt < psq_pkg::ELIMIT)) begin
          held_nxt = '0;
        end else begin
          held_nxt = err_s;
        end
        acc_nxt   = psq_pkg::ALU_W'(dev_full);
        state_nxt = psq_pkg::ST_SUB;
      end

      psq_pkg::ST_SUB: begin
        alu_a       = acc_r;
        alu_b       = phase_r ? psq_pkg::ALU_W'(eavg_r) : psq_pkg::ALU_W'(avg_r);
        alu_sub     = 1'b1;
        acc_nxt     = alu_y;
        num_neg_nxt = alu_y[psq_pkg::ALU_W-1];
        state_nxt   = psq_pkg::ST_ABS;
      end

      psq_pkg::ST_ABS: begin
        alu_a     = '0;
        alu_b     = acc_r;
        alu_sub   = num_neg_r;
        acc_nxt   = alu_y;
        state_nxt = psq_pkg::ST_RND;
      end

      psq_pkg::ST_RND: begin
        // Round to nearest, halves away from zero, by adding half the divisor.
        alu_a     = acc_r;
        alu_b     = psq_pkg::ALU_W'(den >> 1);
        div_nxt   = alu_y[psq_pkg::DIV_W-1:0];
        rem_nxt   = '0;
        cnt_nxt   = psq_pkg::CNT_W'(psq_pkg::DIV_W);
        state_nxt = psq_pkg::ST_DIV;
      end

      psq_pkg::ST_DIV: begin
        // One restoring-division step: the quotient bit shifts into the dividend.
        alu_a   = psq_pkg::ALU_W'({rem_r, div_r[psq_pkg::DIV_W-1]});
        alu_b   = psq_pkg::ALU_W'(den);
        alu_sub = 1'b1;
        if (!alu_y[psq_pkg::ALU_W-1]) begin
          rem_nxt = alu_y[psq_pkg::DEN_W-1:0];
          div_nxt = {div_r[psq_pkg::DIV_W-2:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[psq_pkg::DEN_W-2:0], div_r[psq_pkg::DIV_W-1]};
          div_nxt = {div_r[psq_pkg::DIV_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == psq_pkg::CNT_W'(1)) begin
          state_nxt = psq_pkg::ST_UPD;
        end
      end

      psq_pkg::ST_UPD: begin
        alu_a   = phase_r ? psq_pkg::ALU_W'(eavg_r) : psq_pkg::ALU_W'(avg_r);
        alu_b   = psq_pkg::ALU_W'(div_r);
        alu_sub = num_neg_r;
        if (phase_r) begin
          eavg_nxt  = $signed(alu_y[psq_pkg::EAVG_W-1:0]);
          state_nxt = psq_pkg::ST_DONE;
        end else begin
          avg_nxt = alu_y[psq_pkg::AVG_W-1:0];
          if (in180_r) begin
            // Long run of 180-degree symbols: squelch opens fast.
            if (on_run_r > psq_pkg::SEQ_STOP) begin
              avg_nxt = psq_pkg::AVG_OPEN;
            end else begin
              on_run_nxt = on_run_r + 1'b1;
            end
            off_run_nxt = '0;
          end else begin
            // Long run of 0-degree symbols closes fast, in BPSK only.
            if (off_run_r > psq_pkg::SEQ_STOP) begin
              if (!qpsk) begin
                avg_nxt = psq_pkg::AVG_CLOSE;
              end
            end else begin
              off_run_nxt = off_run_r + 1'b1;
            end
            on_run_nxt = '0;
          end
          state_nxt = psq_pkg::ST_CLAMP;
        end
      end

      psq_pkg::ST_CLAMP: begin
        // The clamped error is kept, then scaled by five for the average.
        held_nxt  = held_c;
        alu_a     = psq_pkg::ALU_W'(held_c) << 2;
        alu_b     = psq_pkg::ALU_W'(held_c);
        acc_nxt   = alu_y;
        phase_nxt = 1'b1;
        state_nxt = psq_pkg::ST_SUB;
      end

      psq_pkg::ST_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          if (agc_r > psq_pkg::AGC_GATE) begin
            level_nxt = level_v;
            open_nxt  = (level_v >= $signed({2'b00, sql_thr_r}));
          end else begin
            level_nxt = '0;
            open_nxt  = 1'b0;
          end
          imd_nxt       = (on_run_r > psq_pkg::IMD_MIN);
          pea_nxt       = eavg_r;
          out_valid_nxt = 1'b1;
          state_nxt     = psq_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = psq_pkg::ST_IDLE;
      end
    endcase
  end

  // Control and persistent state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= psq_pkg::ST_IDLE;
      phase_r     <= 1'b0;
      avg_r       <= psq_pkg::AVG_RESET;
      eavg_r      <= '0;
      held_r      <= '0;
      on_run_r    <= '0;
      off_run_r   <= '0;
      pos_run_r   <= '0;
      neg_run_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      avg_r       <= avg_nxt;
      eavg_r      <= eavg_nxt;
      held_r      <= held_nxt;
      on_run_r    <= on_run_nxt;
      off_run_r   <= off_run_nxt;
      pos_run_r   <= pos_run_nxt;
      neg_run_r   <= neg_run_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and output payload registers
  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    mcand_r    <= mcand_nxt;
    mplier_r   <= mplier_nxt;
    div_r      <= div_nxt;
    rem_r      <= rem_nxt;
    cnt_r      <= cnt_nxt;
    num_neg_r  <= num_neg_nxt;
    diff_neg_r <= diff_neg_nxt;
    in180_r    <= in180_nxt;
    agc_r      <= agc_nxt;
    level_r    <= level_nxt;
    open_r     <= open_nxt;
    imd_r      <= imd_nxt;
    pea_r      <= pea_nxt;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_mode_r   <= psq_pkg::MODE_BPSK;
      sql_speed_r <= psq_pkg::SPEED_W'(75);
      sql_thr_r   <= psq_pkg::THRESH_W'(50);
      fast_afc_r  <= 1'b0;
    end else if (cfg_chan.valid && cfg_chan.ready) begin
      unique case (psq_pkg::cfg_idx_t'(cfg_chan.index))
        psq_pkg::CFG_RX_MODE:   rx_mode_r   <= cfg_chan.data[psq_pkg::MODE_W-1:0];
        psq_pkg::CFG_SQL_SPEED: sql_speed_r <= cfg_chan.data[psq_pkg::SPEED_W-1:0];
        psq_pkg::CFG_SQL_THR:   sql_thr_r   <= cfg_chan.data[psq_pkg::THRESH_W-1:0];
        psq_pkg::CFG_FAST_AFC:  fast_afc_r  <= cfg_chan.data[0];
        default:                fast_afc_r  <= fast_afc_r;
      endcase
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.squelch_level   = level_r;
  assign out_chan.squelch_open    = open_r;
  assign out_chan.imd_valid       = imd_r;
  assign out_chan.phase_error_avg = pea_r;

`ifndef SYNTHESIS
  // An accepted symbol always starts the sequencer.
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r != psq_pkg::ST_IDLE))
    else $error("sequencer stayed idle after an accepted transaction");

  // The last division step always hands over to the update step.
  a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == psq_pkg::ST_DIV && cnt_r == psq_pkg::CNT_W'(1)) |=>
      (state_r == psq_pkg::ST_UPD))
    else $error("division did not end in the update step");

  // After a clamp the held error lies within one unit.
  a_held_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    $past(state_r == psq_pkg::ST_CLAMP) |->
      (held_r <= $signed(psq_pkg::LIM_BPSK) && held_r >= -$signed(psq_pkg::LIM_BPSK)))
    else $error("held phase error escaped its clamp");

  // Run counters stop at 21.
  a_runs_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (on_run_r <= psq_pkg::SEQ_STOP + 1'b1) && (off_run_r <= psq_pkg::SEQ_STOP + 1'b1))
    else $error("on or off run counter ran past its stop");

  // A new result is loaded only when the output register is free or being emptied.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == psq_pkg::ST_DONE && out_valid_r && !out_chan.ready) |=>
      (state_r == psq_pkg::ST_DONE))
    else $error("result register overwritten before it was taken");
`endif

endmodule

[test/psq_squelch_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the PSK squelch estimator: watches the input, result and configuration
// channels, predicts every result and compares it field by field in arrival order.
// Depends on psq_pkg and the interfaces psq_in_if, psq_out_if and psq_cfg_if.
module psq_squelch_checker
  import psq_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  psq_in_if    in_mon,
  psq_out_if   out_mon,
  psq_cfg_if   cfg_mon,
  output int   mismatches,
  output int   results_seen,
  output int   open_seen,
  output int   imd_seen
);

  // 2*pi scaled by 2^32; the radian value is taken above bit 32 with rounding.
  localparam longint TURN_RAD_Q32 = 64'sd26986075409;
  localparam int     RAD_DROP     = 48 - FRAC_BITS;

  typedef struct packed {
    logic signed [LEVEL_W-1:0] level;
    logic                      sql_open;
    logic                      imd;
    logic signed [PEA_W-1:0]   err_avg;
  } sql_result_t;

  sql_result_t pending_results[$];

  rx_mode_t                 mode_r;
  logic [SPEED_W-1:0]       speed_r;
  logic [THRESH_W-1:0]      thresh_r;
  logic                     fast_r;
  logic [AVG_W-1:0]         dev_avg;
  logic [SEQ_W-1:0]         on_run, off_run;
  logic [RUN_W-1:0]         pos_run, neg_run;
  logic signed [HELD_W-1:0] held_err;
  logic signed [EAVG_W-1:0] err_avg;

  // Division rounded to nearest, halves away from zero.
  function automatic longint div_nearest(input longint num, input longint den);
    longint m, q;
    m = (num < 0) ? -num : num;
    q = (m + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic sql_result_t predict_symbol(input logic [PHASE_W-1:0] angle,
                                                 input logic [AGC_W-1:0]   agc);
    sql_result_t r;
    longint p, centre, diff, rad, err, dev, avg, k, lvl, lim, held, eavg;
    bit qpsk, lsb, in180, in0, opened;
    p    = angle;
    qpsk = (mode_r != MODE_BPSK);
    lsb  = (mode_r == MODE_QPSK_LSB);
    k    = (speed_r == 0) ? 1 : speed_r;
    if (qpsk) begin
      in180 = (p >= 8192 && p <= 24576);
      in0   = (p >= 40960 && p <= 57344);
    end else begin
      in180 = (p <= 32768);
      in0   = !in180;
    end
    avg  = dev_avg;
    held = held_err;
    if (in180 || in0) begin
      centre = in180 ? 16384 : 49152;
      diff   = lsb ? centre - p : p - centre;
      rad    = (((diff < 0) ? -diff : diff) * TURN_RAD_Q32 +
                (64'sd1 << (RAD_DROP - 1))) >>> RAD_DROP;
      err    = (diff < 0) ? -rad : rad;
      dev    = (qpsk ? 280 : 150) * rad;
      if (dev < avg) avg += div_nearest(dev - avg, k);
      else           avg += div_nearest(dev - avg, 2 * k);
      if (in180) begin
        if (on_run > 20) avg = 64'sd25 << FRAC_BITS;
        else             on_run++;
        off_run = 0;
      end else begin
        if (off_run > 20) begin
          if (!qpsk) avg = 64'sd100 << FRAC_BITS;
        end else begin
          off_run++;
        end
        on_run = 0;
      end
      held = err;
      if (err >= 0) begin
        if (pos_run < 255) pos_run++;
        neg_run = 0;
      end else begin
        if (neg_run < 255) neg_run++;
        pos_run = 0;
      end
      if (pos_run < 5 && neg_run < 5) held = 0;
    end
    if (agc > 2560) begin
      lvl    = 100 - (avg >>> FRAC_BITS);
      opened = (lvl >= longint'(thresh_r));
    end else begin
      lvl    = 0;
      opened = 1'b0;
    end
    lim = qpsk ? ((64'sd3 << FRAC_BITS) + 2) / 5 : (64'sd1 << FRAC_BITS);
    if (held > lim)  held = lim;
    if (held < -lim) held = -lim;
    eavg = err_avg + div_nearest(5 * held - err_avg, fast_r ? 30 : 100);
    dev_avg    = avg[AVG_W-1:0];
    held_err   = held[HELD_W-1:0];
    err_avg    = eavg[EAVG_W-1:0];
    r.level    = lvl[LEVEL_W-1:0];
    r.sql_open = opened;
    r.imd      = (on_run > 2);
    r.err_avg  = eavg[PEA_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    sql_result_t got, want;
    int bad;
    bad = 0;
    if (!rst_n) begin
      mode_r   = MODE_BPSK;
      speed_r  = 75;
      thresh_r = 50;
      fast_r   = 1'b0;
      dev_avg  = ((2 << FRAC_BITS) + 2) / 5;
      on_run   = '0;
      off_run  = '0;
      pos_run  = '0;
      neg_run  = '0;
      held_err = '0;
      err_avg  = '0;
      pending_results.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_idx_t'(cfg_mon.index))
          CFG_RX_MODE:   mode_r   = rx_mode_t'(cfg_mon.data[MODE_W-1:0]);
          CFG_SQL_SPEED: speed_r  = cfg_mon.data[SPEED_W-1:0];
          CFG_SQL_THR:   thresh_r = cfg_mon.data[THRESH_W-1:0];
          CFG_FAST_AFC:  fast_r   = cfg_mon.data[FAST_W-1:0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        got.level    = out_mon.squelch_level;
        got.sql_open = out_mon.squelch_open;
        got.imd      = out_mon.imd_valid;
        got.err_avg  = out_mon.phase_error_avg;
        if (pending_results.size() == 0) begin
          $error("result transaction arrived with no symbol outstanding");
          bad++;
        end else begin
          want = pending_results.pop_front();
          if (got.level !== want.level) begin
            $error("squelch_level: expected %0d, got %0d", want.level, got.level);
            bad++;
          end
          if (got.sql_open !== want.sql_open) begin
            $error("squelch_open: expected %0b, got %0b", want.sql_open, got.sql_open);
            bad++;
          end
          if (got.imd !== want.imd) begin
            $error("imd_valid: expected %0b, got %0b", want.imd, got.imd);
            bad++;
          end
          if (got.err_avg !== want.err_avg) begin
            $error("phase_error_avg: expected %0d, got %0d", want.err_avg, got.err_avg);
            bad++;
          end
        end
        results_seen <= results_seen + 1;
        if (got.sql_open === 1'b1) open_seen <= open_seen + 1;
        if (got.imd === 1'b1)      imd_seen  <= imd_seen + 1;
      end
      if (in_mon.valid && in_mon.ready)
        pending_results.push_back(predict_symbol(in_mon.phase_angle, in_mon.agc_level));
      if (bad != 0) mismatches <= mismatches + bad;
    end
  end

endmodule

[test/psk_squelch_quality_estimator_top_test.sv]
`timescale 1ns / 100ps
// Top-level testbench of the PSK squelch estimator: clock, reset, stimulus and verdict.
// Depends on psq_pkg, the channel interfaces, the block and psq_squelch_checker.
module psk_squelch_quality_estimator_top_test;
  import psq_pkg::*;

  // Longest stretch without any accepted transaction before the run is abandoned.
  // This leaves a wide margin over the processing of one windowed symbol, even for
  // long sender gaps and receiver stalls.
  localparam int WATCHDOG_LIMIT = 4000;
  // Quiet time after the last result, about one symbol's worth of processing.
  localparam int SETTLE_CYCLES  = 80;
  localparam int NUM_PHASES     = 12;
  localparam int PHASE_SYMBOLS  = 125;

  logic clk;
  logic rst_n;

  psq_in_if  in_chan();
  psq_out_if out_chan();
  psq_cfg_if cfg_chan();

  int send_idle_pct    = 0;
  int recv_stall_pct   = 0;
  int symbols_sent     = 0;
  int settings_applied = 0;
  int quiet_cycles     = 0;
  int mismatches;
  int results_seen;
  int open_seen;
  int imd_seen;

  psk_squelch_quality_estimator_top uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  // The scoreboard only observes; every pin of the block is driven from here.
  psq_squelch_checker scoreboard (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_chan),
    .out_mon      (out_chan),
    .cfg_mon      (cfg_chan),
    .mismatches   (mismatches),
    .results_seen (results_seen),
    .open_seen    (open_seen),
    .imd_seen     (imd_seen)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // The result side is held off through reset, then stalls at random; the stall rate
  // changes from phase to phase.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: any accepted transaction on any channel restarts the count. If the
  // block hangs, or drops a result the drain loop is waiting for, the run ends here.
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
        (cfg_chan.valid && cfg_chan.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired after %0d cycles without a transaction", WATCHDOG_LIMIT);
      $display("[psk_squelch_quality_estimator_top] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one symbol, after a random number of idle cycles, and returns at the edge
  // where it is taken. valid is left high so a back-to-back symbol needs no toggle.
  task automatic send_symbol(input logic [PHASE_W-1:0] angle, input logic [AGC_W-1:0] agc);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.phase_angle <= angle;
    in_chan.agc_level   <= agc;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    symbols_sent++;
  endtask

  // Stops the input side and waits until every symbol has produced its result. Each
  // symbol yields exactly one result, so the block is idle once the counts match.
  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (results_seen < symbols_sent) @(posedge clk);
  endtask

  task automatic put_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= value;
    @(posedge clk);
    while (!cfg_chan.ready) @(posedge clk);
  endtask

  // Writes all four registers back to back. Only called while the block is idle.
  task automatic set_regs(input rx_mode_t mode, input int speed, input int thresh,
                          input bit fast);
    put_reg(CFG_RX_MODE,   CFG_DATA_W'(mode));
    put_reg(CFG_SQL_SPEED, CFG_DATA_W'(speed));
    put_reg(CFG_SQL_THR,   CFG_DATA_W'(thresh));
    put_reg(CFG_FAST_AFC,  CFG_DATA_W'(fast));
    cfg_chan.valid <= 1'b0;
    settings_applied++;
  endtask

  // One burst of symbols. Most bursts are runs in one window with a controlled spread
  // and sign, which is what drives the run counters, the fast open and close, the
  // error gating and the saturation of the sign runs. The rest are runs that switch
  // windows at random, or raw noise, which in QPSK often lands outside both windows.
  task automatic send_burst();
    int kind, count, spread, sign_sel, off, centre;
    bit window, mixed, noise;
    logic [PHASE_W-1:0] angle;
    logic [AGC_W-1:0]   agc;
    kind = $urandom_range(39);
    noise = (kind >= 1 && kind <= 7);
    mixed = (kind >= 8 && kind <= 11);
    if (kind == 0)  count = $urandom_range(300, 260);  // long enough to saturate
    else if (noise) count = $urandom_range(6, 1);
    else            count = $urandom_range(40, 3);
    case ($urandom_range(3))
      0:       spread = $urandom_range(64);
      1:       spread = $urandom_range(512);
      2:       spread = $urandom_range(2048);
      default: spread = $urandom_range(8191);
    endcase
    // Long runs keep one sign so that the sign counters reach their ceiling.
    sign_sel = (kind == 0) ? $urandom_range(1) : $urandom_range(2);
    window   = $urandom_range(1);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) == 0) agc = $urandom_range(2560);
      else                        agc = $urandom_range(24'hFFFFFF, 2561);
      if (noise) begin
        angle = $urandom;
      end else begin
        if (mixed) window = $urandom_range(1);
        centre = window ? 49152 : 16384;
        case (sign_sel)
          0:       off = $urandom_range(spread);
          1:       off = -int'($urandom_range(spread + 1, 1));
          default: off = int'($urandom_range(2 * spread)) - spread;
        endcase
        angle = PHASE_W'(centre + off);
      end
      send_symbol(angle, agc);
    end
  endtask

  initial begin
    rx_mode_t mode_order[4];
    rx_mode_t mode;
    int speed, thresh, target;
    bit fast;
    mode_order = '{MODE_BPSK, MODE_QPSK_USB, MODE_QPSK_LSB, MODE_SPARE};

    // Every input of the block driven here is known from time zero; the result side
    // ready is held low by its own process through reset.
    rst_n                <= 1'b0;
    in_chan.valid        <= 1'b0;
    in_chan.phase_angle  <= '0;
    in_chan.agc_level    <= '0;
    cfg_chan.valid       <= 1'b0;
    cfg_chan.index       <= CFG_RX_MODE;
    cfg_chan.data        <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, run without idling. The first symbols use the reset settings
    // (BPSK, speed 75, threshold 50, slow AFC): angle extremes, the exact half turn
    // that still counts as 180 degrees, both window centres and the AGC gate edge.
    send_symbol(16'd0,     24'd0);
    send_symbol(16'd65535, 24'hFFFFFF);
    send_symbol(16'd32768, 24'd2561);
    send_symbol(16'd32769, 24'd2560);
    send_symbol(16'd16384, 24'h800000);
    send_symbol(16'd49152, 24'h000A01);
    send_symbol(16'd16383, 24'hFFFFFF);
    wait_drained();

    // QPSK lower sideband with a zero speed, which the block treats as one: the four
    // window edges, the angles just outside them, and angles outside both windows.
    set_regs(MODE_QPSK_LSB, 0, 127, 1'b1);
    send_symbol(16'd8192,  24'hFFFFFF);
    send_symbol(16'd24576, 24'hFFFFFF);
    send_symbol(16'd8191,  24'h00FFFF);
    send_symbol(16'd24577, 24'h00FFFF);
    send_symbol(16'd40960, 24'hFFFFFF);
    send_symbol(16'd57344, 24'hFFFFFF);
    send_symbol(16'd40959, 24'h123456);
    send_symbol(16'd57345, 24'h123456);
    send_symbol(16'd32768, 24'hFFFFFF);
    send_symbol(16'd0,     24'hFFFFFF);
    wait_drained();

    // The spare mode code behaves as QPSK upper sideband; largest speed, threshold 0.
    set_regs(MODE_SPARE, 1023, 0, 1'b0);
    send_symbol(16'd16000, 24'hFFFFFF);
    send_symbol(16'd50000, 24'hFFFFFF);
    send_symbol(16'd65535, 24'hFFFFFF);
    send_symbol(16'd8192,  24'd0);
    wait_drained();

    set_regs(MODE_QPSK_USB, 1, 100, 1'b1);
    send_symbol(16'd24576, 24'hFFFFFF);
    send_symbol(16'd12345, 24'hABCDEF);
    send_symbol(16'd45000, 24'h543210);
    send_symbol(16'd60000, 24'hFFFFFF);
    wait_drained();

    // Random part. Each phase drains the block, applies a new setting, picks an idling
    // pattern and then streams bursts. The first phases pin the register extremes.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      mode = mode_order[(ph < 4) ? ph : $urandom_range(3)];
      case (ph)
        0: begin
          speed  = 1;
          thresh = 0;
        end
        1: begin
          speed  = 1000;
          thresh = 100;
        end
        2: begin
          speed  = 0;
          thresh = 127;
        end
        3: begin
          speed  = 1023;
          thresh = $urandom_range(127);
        end
        default: begin
          case ($urandom_range(5))
            0:       speed = 0;
            1:       speed = 1;
            2:       speed = 1000;
            3:       speed = 1023;
            default: speed = $urandom_range(150, 2);
          endcase
          thresh = $urandom_range(127);
        end
      endcase
      fast = (ph < 2) ? ph[0] : $urandom_range(1);

      wait_drained();
      set_regs(mode, speed, thresh, fast);

      case (ph % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 59;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 59;
        end
        default: begin
          send_idle_pct  = 23;
          recv_stall_pct = 23;
        end
      endcase

      target = symbols_sent + PHASE_SYMBOLS;
      while (symbols_sent < target) send_burst();
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d symbols under %0d register settings, %0d results compared",
             symbols_sent, settings_applied, results_seen);
    $display("Squelch was open in %0d results and IMD was valid in %0d; %0d mismatches",
             open_seen, imd_seen, mismatches);
    if (mismatches == 0) begin
      $display("[psk_squelch_quality_estimator_top] OK");
    end else begin
      $display("[psk_squelch_quality_estimator_top] ERROR");
    end
    $finish;
  end

endmodule
